>>> rtl/vsmp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsmp_pkg
// Shared widths, codes and the sequencer state type of the volume sampler.
// ----------------------------------------------------------------------------
package vsmp_pkg;

  localparam int unsigned DEF_MAX_DIM_X = 32;
  localparam int unsigned DEF_MAX_DIM_Y = 32;
  localparam int unsigned DEF_MAX_DIM_Z = 32;

  localparam int unsigned TEXEL_W   = 8;
  localparam int unsigned INDEX_W   = 15;
  localparam int unsigned POS_W     = 20;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned CFG_W     = 6;
  localparam int unsigned SIZE_W    = 9;   // effective size, up to 63
  localparam int unsigned COORD_W   = 8;   // wrapped texel coordinate
  localparam int unsigned TP_W      = 30;  // pos*size - 0.5, Q16
  localparam int unsigned FLOOR_W   = 14;
  localparam int unsigned ROW_W     = 16;
  localparam int unsigned PLANE_W   = 17;
  localparam int unsigned ZOFF_W    = 25;
  localparam int unsigned LX_W      = 24;  // Q16 texel blend
  localparam int unsigned LY_W      = 40;  // Q32 texel blend
  localparam int unsigned ACC_W     = 58;  // Q48 texel blend plus sign
  localparam int unsigned OUT_W     = 16;
  localparam int unsigned STEP_W    = 4;

  // shared multiplier: signed A times unsigned B
  localparam int unsigned MUL_A_W   = 34;
  localparam int unsigned MUL_B_W   = 18;
  localparam int unsigned MUL_P_W   = 52;

  localparam int unsigned PADDR_W   = 4;
  localparam int unsigned PDATA_W   = 32;

  localparam int unsigned HALF_Q16  = 32768;
  localparam int unsigned THREE_Q16 = 196608;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam logic [1:0] REG_SIZE_X = 2'd0;
  localparam logic [1:0] REG_SIZE_Y = 2'd1;
  localparam logic [1:0] REG_SIZE_Z = 2'd2;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_POSMUL = 6'b000010,
    ST_MOD    = 6'b000100,
    ST_ADDR   = 6'b001000,
    ST_READ   = 6'b010000,
    ST_BLEND  = 6'b100000
  } state_e;

endpackage

>>> rtl/vsmp_texel_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsmp_texel_store
// Texel volume memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module vsmp_texel_store #(
  parameter int unsigned DEPTH = 32768,
  parameter int unsigned AW    = 15
) (
  input  logic                         clk_i,
  input  logic                         wr_en_i,
  input  logic [AW-1:0]                wr_addr_i,
  input  logic [vsmp_pkg::TEXEL_W-1:0] wr_data_i,
  input  logic [AW-1:0]                rd_addr_i,
  output logic [vsmp_pkg::TEXEL_W-1:0] rd_data_o
);
  import vsmp_pkg::*;

  logic [TEXEL_W-1:0] mem_q [DEPTH];
  logic [TEXEL_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> rtl/vsmp_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsmp_mul
// Shared multiplier: signed A by unsigned B, product registered.
// ----------------------------------------------------------------------------
module vsmp_mul (
  input  logic                                clk_i,
  input  logic signed [vsmp_pkg::MUL_A_W-1:0] a_i,
  input  logic        [vsmp_pkg::MUL_B_W-1:0] b_i,
  output logic signed [vsmp_pkg::MUL_P_W-1:0] p_o
);
  import vsmp_pkg::*;

  localparam int unsigned FULL_W = MUL_A_W + MUL_B_W + 1;

  logic signed [FULL_W-1:0]  a_ext;
  logic signed [FULL_W-1:0]  b_ext;
  logic signed [FULL_W-1:0]  prod_full;
  logic signed [MUL_P_W-1:0] p_q;

  assign a_ext     = FULL_W'(a_i);
  assign b_ext     = $signed({{(FULL_W-MUL_B_W){1'b0}}, b_i});
  assign prod_full = a_ext * b_ext;

  always_ff @(posedge clk_i) begin
    p_q <= prod_full[MUL_P_W-1:0];
  end

  assign p_o = p_q;

endmodule

>>> rtl/wrapped_trilinear_volume_sampler_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrapped_trilinear_volume_sampler_core
// Texel volume with wrapped trilinear sampling (smoothstep weight along z).
// ----------------------------------------------------------------------------
// Write command: stored on transfer, the next item may follow right after.
// Sample command: the input stalls until the result is issued, and a
//   stalled earlier result holds the new one back.
//   Per axis a position multiply plus 14 remainder steps (one bit a cycle),
//   then address products, eight reads on the one memory port, and the
//   blends; every product goes through one shared 34x18 multiplier.
// Reset clears control and size registers (each 32); texel memory is not
// cleared and holds garbage until written.
// ----------------------------------------------------------------------------
module wrapped_trilinear_volume_sampler_core #(
  parameter int unsigned MAX_DIM_X = vsmp_pkg::DEF_MAX_DIM_X,
  parameter int unsigned MAX_DIM_Y = vsmp_pkg::DEF_MAX_DIM_Y,
  parameter int unsigned MAX_DIM_Z = vsmp_pkg::DEF_MAX_DIM_Z
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                command_i,
  input  logic        [vsmp_pkg::INDEX_W-1:0] texel_index_i,
  input  logic        [vsmp_pkg::TEXEL_W-1:0] texel_value_i,
  input  logic signed [vsmp_pkg::POS_W-1:0]   pos_x_i,
  input  logic signed [vsmp_pkg::POS_W-1:0]   pos_y_i,
  input  logic signed [vsmp_pkg::POS_W-1:0]   pos_z_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic        [vsmp_pkg::OUT_W-1:0]   sample_value_o,
  // register port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic        [vsmp_pkg::PADDR_W-1:0] paddr,
  input  logic        [vsmp_pkg::PDATA_W-1:0] pwdata,
  output logic        [vsmp_pkg::PDATA_W-1:0] prdata,
  output logic                                pready
);
  import vsmp_pkg::*;

  localparam int unsigned DEPTH = MAX_DIM_X * MAX_DIM_Y * MAX_DIM_Z;
  localparam int unsigned AW    = $clog2(DEPTH);

  localparam logic [SIZE_W-1:0] MAX_SX = SIZE_W'(MAX_DIM_X);
  localparam logic [SIZE_W-1:0] MAX_SY = SIZE_W'(MAX_DIM_Y);
  localparam logic [SIZE_W-1:0] MAX_SZ = SIZE_W'(MAX_DIM_Z);

  // start step of MOD, last micro step of the other phases, last axis
  localparam logic [STEP_W-1:0] MOD_TOP    = STEP_W'(FLOOR_W - 1);
  localparam logic [STEP_W-1:0] ADDR_LAST  = 4'd6;
  localparam logic [STEP_W-1:0] READ_LAST  = 4'd8;
  localparam logic [STEP_W-1:0] BLEND_LAST = 4'd11;
  localparam logic [1:0]        AX_Z       = 2'd2;

  localparam logic [CFG_W-1:0] SIZE_RST = 6'd32;

  // register 0 acts as 1, anything above the axis maximum as the maximum
  function automatic logic [SIZE_W-1:0] eff_size(input logic [CFG_W-1:0] r,
                                                 input logic [SIZE_W-1:0] mx);
    if (r == '0) begin
      return SIZE_W'(1);
    end else if (SIZE_W'(r) > mx) begin
      return mx;
    end
    return SIZE_W'(r);
  endfunction

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  state_e                    state_q, state_d;
  logic [STEP_W-1:0]         step_q, step_d;
  logic [1:0]                ax_q, ax_d;
  logic [CFG_W-1:0]          size_x_q, size_y_q, size_z_q;

  logic signed [POS_W-1:0]   pos_q [3];
  logic signed [POS_W-1:0]   pos_d [3];
  logic [FRAC_W-1:0]         frac_q [3];
  logic [FRAC_W-1:0]         frac_d [3];
  logic [COORD_W-1:0]        lo_q [3];
  logic [COORD_W-1:0]        lo_d [3];
  logic [COORD_W-1:0]        hi_q [3];
  logic [COORD_W-1:0]        hi_d [3];
  logic                      neg_q, neg_d;
  logic [FLOOR_W-1:0]        mag_q, mag_d;
  logic [SIZE_W-1:0]         rem_q, rem_d;
  logic [ROW_W-1:0]          row0_q, row0_d, row1_q, row1_d;
  logic [PLANE_W-1:0]        plane_q, plane_d;
  logic [ZOFF_W-1:0]         zoff0_q, zoff0_d, zoff1_q, zoff1_d;
  logic [TEXEL_W-1:0]        tex_q [8];
  logic [TEXEL_W-1:0]        tex_d [8];
  logic [LX_W-1:0]           lx_q [4];
  logic [LX_W-1:0]           lx_d [4];
  logic [LY_W-1:0]           ly_q [2];
  logic [LY_W-1:0]           ly_d [2];
  logic [FRAC_W-1:0]         w_q, w_d;
  logic signed [ACC_W-1:0]   acc_q, acc_d;
  logic                      out_valid_q, out_valid_d;
  logic [OUT_W-1:0]          sample_q, sample_d;

  // --------------------------------------------------------------------------
  // Shared multiplier and texel memory
  // --------------------------------------------------------------------------
  logic signed [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0]        mul_b;
  logic signed [MUL_P_W-1:0] prod_q;

  vsmp_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod_q)
  );

  logic               wr_en;
  logic [AW-1:0]      rd_addr;
  logic [TEXEL_W-1:0] rd_data;

  vsmp_texel_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (AW'(texel_index_i)),
    .wr_data_i (texel_value_i),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // --------------------------------------------------------------------------
  // Handshakes and config
  // --------------------------------------------------------------------------
  logic              in_xfer;
  logic              out_xfer;
  logic              cfg_wr;
  logic [SIZE_W-1:0] size_eff [3];

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_xfer   = out_valid_q && !out_stall_i;
  // writes beyond the store are dropped
  assign wr_en      = in_xfer && (command_i == CMD_WRITE) &&
                      (32'(texel_index_i) < 32'(DEPTH));

  assign size_eff[0] = eff_size(size_x_q, MAX_SX);
  assign size_eff[1] = eff_size(size_y_q, MAX_SY);
  assign size_eff[2] = eff_size(size_z_q, MAX_SZ);

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    case (paddr[3:2])
      REG_SIZE_X: prdata = PDATA_W'(size_x_q);
      REG_SIZE_Y: prdata = PDATA_W'(size_y_q);
      REG_SIZE_Z: prdata = PDATA_W'(size_z_q);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q <= SIZE_RST;
      size_y_q <= SIZE_RST;
      size_z_q <= SIZE_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_SIZE_X: size_x_q <= pwdata[CFG_W-1:0];
        REG_SIZE_Y: size_y_q <= pwdata[CFG_W-1:0];
        REG_SIZE_Z: size_z_q <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  //   POSMUL: pos*size, then split into floor and fraction
  //   MOD:    |floor| mod size, restoring, one bit a cycle, then fix sign
  //   ADDR:   row and plane offsets of the wrapped coordinates
  //   READ:   eight corner reads, corner code {z,y,x}
  //   BLEND:  four x lerps, smoothstep weight, two y lerps, z blend
  // --------------------------------------------------------------------------
  always_comb begin
    logic signed [TP_W-1:0]    tp;
    logic signed [FLOOR_W-1:0] fl;
    logic [SIZE_W:0]           sh;
    logic [SIZE_W-1:0]         rem_n;
    logic [SIZE_W-1:0]         m;
    logic [SIZE_W-1:0]         m1;
    logic [SIZE_W-1:0]         s_sel;
    logic [2:0]                corner;
    logic [AW-1:0]             ax_x;
    logic [AW-1:0]             ax_y;
    logic [AW-1:0]             ax_z;
    logic signed [TEXEL_W:0]   dx;
    logic signed [LX_W:0]      dy;
    logic signed [LY_W:0]      dz;
    logic signed [LX_W+1:0]    xs;
    logic signed [LY_W:0]      ys;
    logic signed [ACC_W-1:0]   r;
    logic [FRAC_W+2:0]         three_m2t;

    state_d     = state_q;
    step_d      = step_q;
    ax_d        = ax_q;
    pos_d       = pos_q;
    frac_d      = frac_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    neg_d       = neg_q;
    mag_d       = mag_q;
    rem_d       = rem_q;
    row0_d      = row0_q;
    row1_d      = row1_q;
    plane_d     = plane_q;
    zoff0_d     = zoff0_q;
    zoff1_d     = zoff1_q;
    tex_d       = tex_q;
    lx_d        = lx_q;
    ly_d        = ly_q;
    w_d         = w_q;
    acc_d       = acc_q;
    out_valid_d = out_xfer ? 1'b0 : out_valid_q;
    sample_d    = sample_q;
    mul_a       = '0;
    mul_b       = '0;
    rd_addr     = '0;

    s_sel  = size_eff[ax_q];
    tp     = TP_W'(prod_q) - TP_W'(HALF_Q16);
    fl     = tp[TP_W-1 -: FLOOR_W];
    sh     = {rem_q, mag_q[step_q]};
    rem_n  = (sh >= {1'b0, s_sel}) ? SIZE_W'(sh - {1'b0, s_sel}) : SIZE_W'(sh);
    m      = (neg_q && (rem_n != '0)) ? (s_sel - rem_n) : rem_n;
    m1     = m + SIZE_W'(1);
    corner = step_q[2:0];
    ax_x   = corner[0] ? AW'(hi_q[0]) : AW'(lo_q[0]);
    ax_y   = corner[1] ? AW'(row1_q)  : AW'(row0_q);
    ax_z   = corner[2] ? AW'(zoff1_q) : AW'(zoff0_q);
    dx     = '0;
    dy     = '0;
    dz     = $signed({1'b0, ly_q[1]}) - $signed({1'b0, ly_q[0]});
    xs     = '0;
    ys     = '0;
    r      = '0;
    three_m2t = (FRAC_W+3)'(THREE_Q16) - (FRAC_W+3)'({frac_q[2], 1'b0});

    case (state_q)
      ST_IDLE: begin
        if (in_xfer && (command_i == CMD_SAMPLE)) begin
          pos_d[0] = pos_x_i;
          pos_d[1] = pos_y_i;
          pos_d[2] = pos_z_i;
          ax_d     = '0;
          step_d   = '0;
          state_d  = ST_POSMUL;
        end
      end

      ST_POSMUL: begin
        if (step_q == '0) begin
          mul_a  = MUL_A_W'(pos_q[ax_q]);
          mul_b  = MUL_B_W'(s_sel);
          step_d = 4'd1;
        end else begin
          // floor toward minus infinity is the arithmetic top slice
          frac_d[ax_q] = tp[FRAC_W-1:0];
          neg_d        = fl[FLOOR_W-1];
          mag_d        = fl[FLOOR_W-1] ? FLOOR_W'(-fl) : FLOOR_W'(fl);
          rem_d        = '0;
          step_d       = MOD_TOP;
          state_d      = ST_MOD;
        end
      end

      ST_MOD: begin
        rem_d = rem_n;
        if (step_q == '0) begin
          lo_d[ax_q] = COORD_W'(m);
          hi_d[ax_q] = (m1 == s_sel) ? '0 : COORD_W'(m1);
          step_d     = '0;
          if (ax_q == AX_Z) begin
            state_d = ST_ADDR;
          end else begin
            ax_d    = ax_q + 2'd1;
            state_d = ST_POSMUL;
          end
        end else begin
          step_d = step_q - 4'd1;
        end
      end

      ST_ADDR: begin
        step_d = step_q + 4'd1;
        case (step_q)
          4'd0: begin
            mul_a = MUL_A_W'(lo_q[1]);
            mul_b = MUL_B_W'(size_eff[0]);
          end
          4'd1: begin
            row0_d = prod_q[ROW_W-1:0];
            mul_a  = MUL_A_W'(hi_q[1]);
            mul_b  = MUL_B_W'(size_eff[0]);
          end
          4'd2: begin
            row1_d = prod_q[ROW_W-1:0];
            mul_a  = MUL_A_W'(size_eff[0]);
            mul_b  = MUL_B_W'(size_eff[1]);
          end
          4'd3: begin
            plane_d = prod_q[PLANE_W-1:0];
          end
          4'd4: begin
            mul_a = MUL_A_W'(plane_q);
            mul_b = MUL_B_W'(lo_q[2]);
          end
          4'd5: begin
            zoff0_d = prod_q[ZOFF_W-1:0];
            mul_a   = MUL_A_W'(plane_q);
            mul_b   = MUL_B_W'(hi_q[2]);
          end
          default: begin
            zoff1_d = prod_q[ZOFF_W-1:0];
            if (step_q == ADDR_LAST) begin
              step_d  = '0;
              state_d = ST_READ;
            end
          end
        endcase
      end

      ST_READ: begin
        // address issued in one step, data captured in the next
        rd_addr = ax_x + ax_y + ax_z;
        if (step_q != '0) begin
          tex_d[3'(step_q - 4'd1)] = rd_data;
        end
        if (step_q == READ_LAST) begin
          step_d  = '0;
          state_d = ST_BLEND;
        end else begin
          step_d = step_q + 4'd1;
        end
      end

      ST_BLEND: begin
        step_d = step_q + 4'd1;
        // x lerp of pair p = step-1 (texels 2p, 2p+1)
        if ((step_q >= 4'd1) && (step_q <= 4'd4)) begin
          xs = $signed({2'b00, tex_q[{step_q[1:0] - 2'd1, 1'b0}], 16'h0000}) +
               (LX_W+2)'(prod_q);
          lx_d[2'(step_q - 4'd1)] = LX_W'(xs);
        end
        case (step_q)
          4'd0, 4'd1, 4'd2, 4'd3: begin
            dx    = $signed({1'b0, tex_q[{step_q[1:0], 1'b1}]}) -
                    $signed({1'b0, tex_q[{step_q[1:0], 1'b0}]});
            mul_a = MUL_A_W'(dx);
            mul_b = MUL_B_W'(frac_q[0]);
          end
          4'd4: begin
            mul_a = MUL_A_W'(frac_q[2]);
            mul_b = MUL_B_W'(frac_q[2]);
          end
          4'd5: begin
            // tz^2 times (3 - 2 tz)
            mul_a = MUL_A_W'(prod_q[31:0]);
            mul_b = MUL_B_W'(three_m2t);
          end
          4'd6: begin
            w_d   = prod_q[47:32];
            dy    = $signed({1'b0, lx_q[1]}) - $signed({1'b0, lx_q[0]});
            mul_a = MUL_A_W'(dy);
            mul_b = MUL_B_W'(frac_q[1]);
          end
          4'd7: begin
            ys      = $signed({1'b0, lx_q[0], 16'h0000}) + (LY_W+1)'(prod_q);
            ly_d[0] = LY_W'(ys);
            dy      = $signed({1'b0, lx_q[3]}) - $signed({1'b0, lx_q[2]});
            mul_a   = MUL_A_W'(dy);
            mul_b   = MUL_B_W'(frac_q[1]);
          end
          4'd8: begin
            ys      = $signed({1'b0, lx_q[2], 16'h0000}) + (LY_W+1)'(prod_q);
            ly_d[1] = LY_W'(ys);
          end
          4'd9: begin
            // z difference is 41 bits: low 16 bits first, high part next
            mul_a = MUL_A_W'(dz[15:0]);
            mul_b = MUL_B_W'(w_q);
          end
          4'd10: begin
            acc_d = $signed({2'b00, ly_q[0], 16'h0000}) + ACC_W'(prod_q);
            mul_a = MUL_A_W'($signed(dz[LY_W:16]));
            mul_b = MUL_B_W'(w_q);
          end
          default: begin
            // keep the high partial product alive while the result waits
            mul_a = MUL_A_W'($signed(dz[LY_W:16]));
            mul_b = MUL_B_W'(w_q);
            r = acc_q + (ACC_W'(prod_q) <<< 16);
            if (!out_valid_q || out_xfer) begin
              out_valid_d = 1'b1;
              sample_d    = r[ACC_W-1] ? '0 : r[55:40];
              step_d      = '0;
              state_d     = ST_IDLE;
            end else begin
              step_d = BLEND_LAST;
            end
          end
        endcase
      end

      default: begin
        state_d = ST_IDLE;
        step_d  = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      ax_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      ax_q        <= ax_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    frac_q   <= frac_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    neg_q    <= neg_d;
    mag_q    <= mag_d;
    rem_q    <= rem_d;
    row0_q   <= row0_d;
    row1_q   <= row1_d;
    plane_q  <= plane_d;
    zoff0_q  <= zoff0_d;
    zoff1_q  <= zoff1_d;
    tex_q    <= tex_d;
    lx_q     <= lx_d;
    ly_q     <= ly_d;
    w_q      <= w_d;
    acc_q    <= acc_d;
    sample_q <= sample_d;
  end

  assign out_valid_o    = out_valid_q;
  assign sample_value_o = sample_q;

endmodule

>>> rtl/vsmp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsmp_checker
// Port-level checks of the volume sampler, bound to the top level.
// ----------------------------------------------------------------------------
module vsmp_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        command_i,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [vsmp_pkg::OUT_W-1:0]  sample_value_o,
  input logic                        pready
);
  import vsmp_pkg::*;

  // a sample keeps the block busy after its transfer
  a_sample_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (command_i == CMD_SAMPLE)) |=> in_stall_o)
    else $error("sample accepted but input not stalled");

  // a write makes no result
  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (command_i == CMD_WRITE) && !out_valid_o)
      |=> !out_valid_o)
    else $error("result after texel write");

  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (sample_value_o <= 16'hFF00))
    else $error("sample above 255.0");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(sample_value_o)))
    else $error("stalled result changed");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind wrapped_trilinear_volume_sampler_core vsmp_checker u_vsmp_checker (.*);
